### hdl/dic_pkg.sv
// ----------------------------------------------------------------------------
// dic_pkg
// Shared types and constants for the debounced interlock controller.
// ----------------------------------------------------------------------------
package dic_pkg;

	// number of sensor lanes, 1 to 16
	localparam int unsigned SENSOR_COUNT = 4;

	// fixed widths of the poll and result fields
	localparam int unsigned FIELD_W    = 4;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned DEBOUNCE_W = 16;

	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(20);

	typedef logic [TIME_W-1:0]       time_t;
	typedef logic [DEBOUNCE_W-1:0]   debounce_t;
	typedef logic [FIELD_W-1:0]      field_t;
	typedef logic [SENSOR_COUNT-1:0] lane_vec_t;

	// one poll of the pins
	typedef struct packed {
		field_t sensor_pins;
		logic   remote_stop_pin;
		logic   trip_pin;
		logic   reset_request;
		logic   motor_request;
		time_t  now_ms;
	} poll_t;

	// one result of a poll
	typedef struct packed {
		field_t stable_sensors;
		field_t valve_pins;
		logic   motor_pin;
		logic   fault_active;
		logic   remote_stop_seen;
		logic   trip_seen;
	} result_t;

	// interlock request bits handed from the top to the merging stage
	typedef struct packed {
		logic stop_seen;
		logic trip_seen;
		logic reset_request;
		logic motor_request;
	} ilk_req_t;

endpackage

### hdl/dic_if.sv
// ----------------------------------------------------------------------------
// dic_if
// Valid/ready channels for poll items and result items.
// ----------------------------------------------------------------------------
interface dic_poll_if;
	import dic_pkg::*;

	logic  valid;
	logic  ready;
	poll_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dic_result_if;
	import dic_pkg::*;

	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/dic_lane.sv
// ----------------------------------------------------------------------------
// dic_lane
// One sensor debounce lane: change stamp, previous raw level, settled level.
// ----------------------------------------------------------------------------
module dic_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                raw,
	input  dic_pkg::time_t      now_ms,
	input  dic_pkg::debounce_t  debounce_ms,
	output logic                settled
);
	import dic_pkg::*;

	time_t stamp_q;
	logic  prev_q;
	logic  settled_q;
	logic  changed;
	time_t elapsed;
	logic  expired;

	// a fresh change restarts the hold time at zero
	assign changed = raw != prev_q;
	assign elapsed = changed ? '0 : (now_ms - stamp_q);
	assign expired = elapsed > TIME_W'(debounce_ms);
	assign settled = expired ? raw : settled_q;

	// lane state, updated on each poll transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_q   <= '0;
			prev_q    <= 1'b0;
			settled_q <= 1'b0;
		end else if (en) begin
			if (changed) begin
				stamp_q <= now_ms;
			end
			prev_q    <= raw;
			settled_q <= settled;
		end
	end

endmodule

### hdl/dic_merge.sv
// ----------------------------------------------------------------------------
// dic_merge
// Combines lane levels with the fault latch into one result item.
// ----------------------------------------------------------------------------
module dic_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  dic_pkg::lane_vec_t  lanes,
	input  dic_pkg::ilk_req_t   req,
	output dic_pkg::result_t    result
);
	import dic_pkg::*;

	logic                             fault_q;
	logic                             fault_d;
	logic [SENSOR_COUNT+FIELD_W-1:0]  lanes_ext;
	field_t                           stable;

	// stop or trip wins over a reset request
	always_comb begin
		fault_d = fault_q;
		if (req.stop_seen || req.trip_seen) begin
			fault_d = 1'b1;
		end else if (fault_q && req.reset_request) begin
			fault_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q <= 1'b0;
		end else if (en) begin
			fault_q <= fault_d;
		end
	end

	// lanes past the field are dropped, missing lanes read inactive
	assign lanes_ext = {FIELD_W'(0), lanes};
	assign stable    = lanes_ext[FIELD_W-1:0];

	// drives are active low and all off during a fault
	always_comb begin
		result.stable_sensors   = stable;
		result.fault_active     = fault_d;
		result.remote_stop_seen = req.stop_seen;
		result.trip_seen        = req.trip_seen;
		if (fault_d) begin
			result.valve_pins = '1;
			result.motor_pin  = 1'b1;
		end else begin
			result.valve_pins = ~stable;
			result.motor_pin  = ~req.motor_request;
		end
	end

endmodule

### hdl/debounced_interlock_controller_top.sv
// ----------------------------------------------------------------------------
// debounced_interlock_controller_top
// Per-sensor debounce lanes with a latched stop/trip interlock.
//
// channel   dir  handshake      payload
// poll      in   valid/ready    dic_pkg::poll_t
// result    out  valid/ready    dic_pkg::result_t
// cfg       in   cfg_we         cfg_wdata = debounce_ms
//
// one poll per cycle unless a result stalls; each result appears in the
// cycle after its transfer, held in a single output register.
// lane and fault state update at the poll transfer, so the next poll
// may follow at once; the lane subtract and compare set the path.
// arst_n clears lanes, fault latch and output valid; debounce_ms resets to 20.
// a stalled result holds poll ready low until the result register frees.
// ----------------------------------------------------------------------------
module debounced_interlock_controller_top (
	input  logic               clk,
	input  logic               arst_n,
	dic_poll_if.sink           poll,
	dic_result_if.source       result,
	input  logic               cfg_we,
	input  dic_pkg::debounce_t cfg_wdata
);
	import dic_pkg::*;

	debounce_t                        debounce_q;
	logic                             take;
	logic [SENSOR_COUNT+FIELD_W-1:0]  pins_ext;
	lane_vec_t                        lanes;
	ilk_req_t                         req;
	result_t                          merged;
	result_t                          data_s1;
	logic                             valid_s1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
		end else if (cfg_we) begin
			debounce_q <= cfg_wdata;
		end
	end

	// accept while the result register is empty or draining
	assign poll.ready = !valid_s1 || result.ready;
	assign take       = poll.valid && poll.ready;

	// pin bits beyond the field read 0, so their inverted lanes see level 1
	assign pins_ext = {SENSOR_COUNT'(0), poll.data.sensor_pins};

	for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_lane
		dic_lane u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.en          (take),
			.raw         (~pins_ext[i]),
			.now_ms      (poll.data.now_ms),
			.debounce_ms (debounce_q),
			.settled     (lanes[i])
		);
	end

	assign req.stop_seen     = poll.data.remote_stop_pin;
	assign req.trip_seen     = ~poll.data.trip_pin;
	assign req.reset_request = poll.data.reset_request;
	assign req.motor_request = poll.data.motor_request;

	dic_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (take),
		.lanes  (lanes),
		.req    (req),
		.result (merged)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_s1 <= merged;
		end
	end

	assign result.valid = valid_s1;
	assign result.data  = data_s1;

endmodule

### hdl/dic_checker.sv
// ----------------------------------------------------------------------------
// dic_checker
// Port-level checks on the interlock controller, bound to the top level.
// ----------------------------------------------------------------------------
module dic_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              poll_valid,
	input logic              poll_ready,
	input logic              result_valid,
	input logic              result_ready,
	input dic_pkg::result_t  result_data
);
	import dic_pkg::*;

	// a stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_data))
		else $error("result changed while stalled");

	// every poll transfer yields a result on the next cycle
	a_resp: assert property (@(posedge clk) disable iff (!arst_n)
		poll_valid && poll_ready |=> result_valid)
		else $error("poll transfer without result");

	// a stop or trip in the poll always reports the fault latched
	a_latch: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_data.remote_stop_seen || result_data.trip_seen)
		|-> result_data.fault_active)
		else $error("stop or trip without fault");

	// all drives off during a fault
	a_off: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.fault_active
		|-> result_data.valve_pins == '1 && result_data.motor_pin)
		else $error("drive on during fault");

	// valves mirror the debounced sensors when no fault holds
	a_mirror: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_data.fault_active
		|-> result_data.valve_pins == ~result_data.stable_sensors)
		else $error("valves do not mirror sensors");

endmodule

bind debounced_interlock_controller_top dic_checker u_dic_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.poll_valid   (poll.valid),
	.poll_ready   (poll.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_data  (result.data)
);
